// ===== rtl/lmwq_pkg.sv =====
// Shared types and codes for the lock manager with FIFO wait queues.
// Holds the request and response beat structs, the operation and status codes.
// No dependencies.
package lmwq_pkg;

  localparam logic OP_LOCK   = 1'b0;
  localparam logic OP_UNLOCK = 1'b1;

  localparam logic [2:0] ST_GRANTED     = 3'd0;
  localparam logic [2:0] ST_QUEUED      = 3'd1;
  localparam logic [2:0] ST_NO_SPACE    = 3'd2;
  localparam logic [2:0] ST_HANDED_OVER = 3'd3;
  localparam logic [2:0] ST_RELEASED    = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND   = 3'd5;
  localparam logic [2:0] ST_NOT_OWNER   = 3'd6;

  typedef struct packed {
    logic        operation;
    logic [7:0]  thread_id;
    logic [31:0] lock_id;
  } lmwq_req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] next_owner;
    logic [4:0] free_lock_slots;
    logic [5:0] free_waiter_slots;
  } lmwq_rsp_t;

endpackage

// ===== rtl/lock_manager_with_wait_queues.sv =====
// Lock manager with FIFO wait queues: lock table, shared waiter pool and sequencer.
// Depends on lmwq_pkg for the beat structs and the operation and status codes.
//
// Usage: each request beat on the in_ channel names a thread and a lock id and asks
// to lock or unlock it. Exactly one response beat leaves on the out_ channel for
// each request, carrying the status, the new holder on a hand-over and the free
// lock slot and waiter entry counts after the request.
// A request is taken at a clock edge where in_valid is high and in_stall is low;
// a response likewise where out_valid is high and out_stall is low.
// One request is processed at a time. A single comparator walks the lock table
// and the waiter pool together, one entry a cycle, so the walk lasts as long as the
// larger of the two. A hand-over reads the waiter pool once more before the
// response. The sequencer returns to idle when the response is registered, and
// the next request beat can be taken from then on. The response register frees
// the input side, so a new request may be taken while the previous response is
// still waiting for the receiver.
// If the receiver stalls, the finished request waits in the sequencer and no
// further request is taken until the response register empties.
// Reset (rst_n low, synchronous) empties the lock table and the waiter pool and
// restores the free counts. No clearing pass is needed: the block is ready at once.
module lock_manager_with_wait_queues #(
  parameter int LOCK_SLOTS     = 16,
  parameter int WAITER_SLOTS   = 32,
  parameter int THREAD_ID_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lmwq_pkg::lmwq_req_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output lmwq_pkg::lmwq_rsp_t out_data
);
  import lmwq_pkg::*;

  localparam int TW  = (THREAD_ID_BITS < 8) ? THREAD_ID_BITS : 8;
  localparam int LI  = (LOCK_SLOTS > 1) ? $clog2(LOCK_SLOTS) : 1;
  localparam int WI  = (WAITER_SLOTS > 1) ? $clog2(WAITER_SLOTS) : 1;
  localparam int NS  = (LOCK_SLOTS > WAITER_SLOTS) ? LOCK_SLOTS : WAITER_SLOTS;
  localparam int CW  = $clog2(NS + 1);
  localparam int LCW = $clog2(LOCK_SLOTS + 1);
  localparam int WCW = $clog2(WAITER_SLOTS + 1);

  typedef struct packed {
    logic [TW-1:0] holder;
    logic [WI-1:0] head;
    logic [WI-1:0] tail;
  } slot_info_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_HAND,
    S_EMIT
  } state_t;

  state_t state_r;

  logic          req_op_r;
  logic [TW-1:0] req_thr_r;
  logic [31:0]   req_id_r;
  logic [CW-1:0] cnt_r;

  logic             p_vld_r;
  logic [LI-1:0]    p_idx_r;
  logic [31:0]      p_id_r;
  slot_info_t       p_info_r;

  logic             hit_r;
  logic [LI-1:0]    hit_idx_r;
  slot_info_t       hit_info_r;
  logic             fs_ok_r;
  logic [LI-1:0]    fs_idx_r;
  logic             fw_ok_r;
  logic [WI-1:0]    fw_idx_r;

  logic [LOCK_SLOTS-1:0]   slot_active_r;
  logic [LOCK_SLOTS-1:0]   slot_nonempty_r;
  logic [WAITER_SLOTS-1:0] waiter_used_r;
  logic [LCW-1:0]          free_slot_cnt_r;
  logic [WCW-1:0]          free_waiter_cnt_r;

  logic [2:0]    res_status_r;
  logic [TW-1:0] res_next_r;
  logic [TW-1:0] wthr_rd_r;
  logic [WI-1:0] wlink_rd_r;

  logic      out_valid_r;
  lmwq_rsp_t out_data_r;

  logic [31:0]   id_mem    [LOCK_SLOTS];
  slot_info_t    info_mem  [LOCK_SLOTS];
  logic [TW-1:0] wthr_mem  [WAITER_SLOTS];
  logic [WI-1:0] wlink_mem [WAITER_SLOTS];

  logic          scan_slot;
  logic          scan_waiter;
  logic [LI-1:0] scan_sidx;
  logic [WI-1:0] scan_widx;
  logic          cmp_hit;
  logic          hit_nonempty;
  logic          do_queue;
  logic          do_grant;
  logic          do_hand;
  logic          do_release;
  logic [2:0]    dec_status;

  logic          id_we;
  logic [LI-1:0] id_waddr;
  logic          info_we;
  logic [LI-1:0] info_waddr;
  slot_info_t    info_wdata;
  logic          wthr_we;
  logic          wlink_we;

  assign scan_slot   = (state_r == S_SCAN) && (cnt_r < CW'(LOCK_SLOTS));
  assign scan_waiter = (state_r == S_SCAN) && (cnt_r < CW'(WAITER_SLOTS));
  assign scan_sidx   = cnt_r[LI-1:0];
  assign scan_widx   = cnt_r[WI-1:0];
  assign cmp_hit     = p_vld_r && slot_active_r[p_idx_r] && (p_id_r == req_id_r);
  assign hit_nonempty = slot_nonempty_r[hit_idx_r];

  always_comb begin
    do_queue   = 1'b0;
    do_grant   = 1'b0;
    do_hand    = 1'b0;
    do_release = 1'b0;
    dec_status = ST_NO_SPACE;
    if (req_op_r == OP_LOCK) begin
      if (hit_r) begin
        if (fw_ok_r) begin
          do_queue   = 1'b1;
          dec_status = ST_QUEUED;
        end
      end else if (fs_ok_r) begin
        do_grant   = 1'b1;
        dec_status = ST_GRANTED;
      end
    end else begin
      if (!hit_r) begin
        dec_status = ST_NOT_FOUND;
      end else if (hit_info_r.holder != req_thr_r) begin
        dec_status = ST_NOT_OWNER;
      end else if (hit_nonempty) begin
        do_hand    = 1'b1;
        dec_status = ST_HANDED_OVER;
      end else begin
        do_release = 1'b1;
        dec_status = ST_RELEASED;
      end
    end
  end

  always_comb begin
    id_we      = 1'b0;
    id_waddr   = fs_idx_r;
    info_we    = 1'b0;
    info_waddr = hit_idx_r;
    info_wdata = hit_info_r;
    wthr_we    = 1'b0;
    wlink_we   = 1'b0;
    case (state_r)
      S_DECIDE: begin
        if (do_queue) begin
          wthr_we         = 1'b1;
          wlink_we        = hit_nonempty;
          info_we         = 1'b1;
          info_wdata.head = hit_nonempty ? hit_info_r.head : fw_idx_r;
          info_wdata.tail = fw_idx_r;
        end else if (do_grant) begin
          id_we             = 1'b1;
          info_we           = 1'b1;
          info_waddr        = fs_idx_r;
          info_wdata.holder = req_thr_r;
          info_wdata.head   = '0;
          info_wdata.tail   = '0;
        end
      end
      S_HAND: begin
        info_we           = 1'b1;
        info_wdata.holder = wthr_rd_r;
        info_wdata.head   = (hit_info_r.head == hit_info_r.tail) ? hit_info_r.head
                                                                 : wlink_rd_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (id_we) begin
      id_mem[id_waddr] <= req_id_r;
    end
    if (info_we) begin
      info_mem[info_waddr] <= info_wdata;
    end
    if (wthr_we) begin
      wthr_mem[fw_idx_r] <= req_thr_r;
    end
    if (wlink_we) begin
      wlink_mem[hit_info_r.tail] <= fw_idx_r;
    end
    p_idx_r    <= scan_sidx;
    p_id_r     <= id_mem[scan_sidx];
    p_info_r   <= info_mem[scan_sidx];
    wthr_rd_r  <= wthr_mem[hit_info_r.head];
    wlink_rd_r <= wlink_mem[hit_info_r.head];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= S_IDLE;
      cnt_r             <= '0;
      p_vld_r           <= 1'b0;
      hit_r             <= 1'b0;
      fs_ok_r           <= 1'b0;
      fw_ok_r           <= 1'b0;
      slot_active_r     <= '0;
      slot_nonempty_r   <= '0;
      waiter_used_r     <= '0;
      free_slot_cnt_r   <= LCW'(LOCK_SLOTS);
      free_waiter_cnt_r <= WCW'(WAITER_SLOTS);
      out_valid_r       <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && (state_r != S_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      p_vld_r <= scan_slot;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            req_op_r  <= in_data.operation;
            req_thr_r <= in_data.thread_id[TW-1:0];
            req_id_r  <= in_data.lock_id;
            cnt_r     <= '0;
            hit_r     <= 1'b0;
            fs_ok_r   <= 1'b0;
            fw_ok_r   <= 1'b0;
            state_r   <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (cmp_hit && !hit_r) begin
            hit_r      <= 1'b1;
            hit_idx_r  <= p_idx_r;
            hit_info_r <= p_info_r;
          end
          if (scan_slot && !fs_ok_r && !slot_active_r[scan_sidx]) begin
            fs_ok_r  <= 1'b1;
            fs_idx_r <= scan_sidx;
          end
          if (scan_waiter && !fw_ok_r && !waiter_used_r[scan_widx]) begin
            fw_ok_r  <= 1'b1;
            fw_idx_r <= scan_widx;
          end
          if (cnt_r == CW'(NS)) begin
            state_r <= S_DECIDE;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_DECIDE: begin
          res_status_r <= dec_status;
          res_next_r   <= '0;
          if (do_queue) begin
            waiter_used_r[fw_idx_r]    <= 1'b1;
            slot_nonempty_r[hit_idx_r] <= 1'b1;
            free_waiter_cnt_r          <= free_waiter_cnt_r - 1'b1;
          end
          if (do_grant) begin
            slot_active_r[fs_idx_r]   <= 1'b1;
            slot_nonempty_r[fs_idx_r] <= 1'b0;
            free_slot_cnt_r           <= free_slot_cnt_r - 1'b1;
          end
          if (do_release) begin
            slot_active_r[hit_idx_r]   <= 1'b0;
            slot_nonempty_r[hit_idx_r] <= 1'b0;
            free_slot_cnt_r            <= free_slot_cnt_r + 1'b1;
          end
          state_r <= do_hand ? S_HAND : S_EMIT;
        end
        S_HAND: begin
          res_next_r <= wthr_rd_r;
          if (hit_info_r.head == hit_info_r.tail) begin
            slot_nonempty_r[hit_idx_r] <= 1'b0;
          end
          waiter_used_r[hit_info_r.head] <= 1'b0;
          free_waiter_cnt_r              <= free_waiter_cnt_r + 1'b1;
          state_r                        <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r                  <= 1'b1;
            out_data_r.status            <= res_status_r;
            out_data_r.next_owner        <= 8'(res_next_r);
            out_data_r.free_lock_slots   <= 5'(free_slot_cnt_r);
            out_data_r.free_waiter_slots <= 6'(free_waiter_cnt_r);
            state_r                      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== bench/lmwq_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the lock manager: watches the request and response channels,
// keeps its own lock table and waiter pool, and compares every response beat.
// Depends on lmwq_pkg for the beat structs and the operation and status codes.
module lmwq_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  lmwq_pkg::lmwq_req_t in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  lmwq_pkg::lmwq_rsp_t out_data,
  output int                  fail_count,
  output int                  pending
);
  import lmwq_pkg::*;

  localparam int SLOTS   = 16;
  localparam int WAITERS = 32;

  logic        slot_on    [SLOTS];
  logic [31:0] slot_key   [SLOTS];
  logic [7:0]  slot_owner [SLOTS];
  logic [4:0]  q_head     [SLOTS];
  logic [4:0]  q_tail     [SLOTS];
  logic        q_busy     [SLOTS];
  logic        wt_used    [WAITERS];
  logic [7:0]  wt_thread  [WAITERS];
  logic [4:0]  wt_next    [WAITERS];
  int          free_slots;
  int          free_waiters;
  int          fails;
  lmwq_rsp_t   expected_rsp_q[$];

  function automatic void clear_tables();
    for (int i = 0; i < SLOTS; i++) begin
      slot_on[i]    = 1'b0;
      slot_key[i]   = '0;
      slot_owner[i] = '0;
      q_head[i]     = '0;
      q_tail[i]     = '0;
      q_busy[i]     = 1'b0;
    end
    for (int i = 0; i < WAITERS; i++) begin
      wt_used[i]   = 1'b0;
      wt_thread[i] = '0;
      wt_next[i]   = '0;
    end
    free_slots   = SLOTS;
    free_waiters = WAITERS;
  endfunction

  function automatic lmwq_rsp_t serve_request(lmwq_req_t req);
    lmwq_rsp_t  rsp;
    int         s;
    int         w;
    int         n;
    logic [7:0] thr;
    thr = req.thread_id;
    rsp = '0;
    s = -1;
    for (int i = 0; i < SLOTS; i++)
      if (s < 0 && slot_on[i] && slot_key[i] == req.lock_id) s = i;
    if (req.operation == OP_LOCK) begin
      if (s >= 0) begin
        w = -1;
        for (int i = 0; i < WAITERS; i++)
          if (w < 0 && !wt_used[i]) w = i;
        if (w < 0) begin
          rsp.status = ST_NO_SPACE;
        end else begin
          wt_used[w]   = 1'b1;
          wt_thread[w] = thr;
          wt_next[w]   = '0;
          if (q_busy[s]) begin
            wt_next[q_tail[s]] = 5'(w);
          end else begin
            q_head[s] = 5'(w);
            q_busy[s] = 1'b1;
          end
          q_tail[s] = 5'(w);
          free_waiters--;
          rsp.status = ST_QUEUED;
        end
      end else begin
        n = -1;
        for (int i = 0; i < SLOTS; i++)
          if (n < 0 && !slot_on[i]) n = i;
        if (n < 0) begin
          rsp.status = ST_NO_SPACE;
        end else begin
          slot_on[n]    = 1'b1;
          slot_key[n]   = req.lock_id;
          slot_owner[n] = thr;
          q_busy[n]     = 1'b0;
          q_head[n]     = '0;
          q_tail[n]     = '0;
          free_slots--;
          rsp.status = ST_GRANTED;
        end
      end
    end else begin
      if (s < 0) begin
        rsp.status = ST_NOT_FOUND;
      end else if (slot_owner[s] != thr) begin
        rsp.status = ST_NOT_OWNER;
      end else if (q_busy[s]) begin
        w = q_head[s];
        rsp.next_owner = wt_thread[w];
        slot_owner[s]  = wt_thread[w];
        if (5'(w) == q_tail[s]) q_busy[s] = 1'b0;
        else q_head[s] = wt_next[w];
        wt_used[w]   = 1'b0;
        wt_thread[w] = '0;
        free_waiters++;
        rsp.status = ST_HANDED_OVER;
      end else begin
        slot_on[s]    = 1'b0;
        slot_key[s]   = '0;
        slot_owner[s] = '0;
        q_busy[s]     = 1'b0;
        free_slots++;
        rsp.status = ST_RELEASED;
      end
    end
    rsp.free_lock_slots   = 5'(free_slots);
    rsp.free_waiter_slots = 6'(free_waiters);
    return rsp;
  endfunction

  always @(posedge clk) begin : watch
    lmwq_rsp_t want;
    if (!rst_n) begin
      clear_tables();
      expected_rsp_q.delete();
      fails = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_rsp_q.size() == 0) begin
          $error("Response beat with no request outstanding: %p", out_data);
          fails++;
        end else begin
          want = expected_rsp_q.pop_front();
          if (out_data.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, out_data.status);
            fails++;
          end
          if (out_data.next_owner !== want.next_owner) begin
            $error("next_owner mismatch: expected %0d, actual %0d",
                   want.next_owner, out_data.next_owner);
            fails++;
          end
          if (out_data.free_lock_slots !== want.free_lock_slots) begin
            $error("free_lock_slots mismatch: expected %0d, actual %0d",
                   want.free_lock_slots, out_data.free_lock_slots);
            fails++;
          end
          if (out_data.free_waiter_slots !== want.free_waiter_slots) begin
            $error("free_waiter_slots mismatch: expected %0d, actual %0d",
                   want.free_waiter_slots, out_data.free_waiter_slots);
            fails++;
          end
        end
      end
      if (in_valid && !in_stall) expected_rsp_q.push_back(serve_request(in_data));
    end
    fail_count <= fails;
    pending    <= expected_rsp_q.size();
  end

endmodule

// ===== bench/tb_lock_manager_with_wait_queues.sv =====
`timescale 1ns / 1ps
// Top of the lock manager bench: clock, reset, request stimulus and receiver stalls.
// Depends on lmwq_pkg, the lock_manager_with_wait_queues block and lmwq_checker.
module tb_lock_manager_with_wait_queues;
  import lmwq_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  lmwq_req_t in_data;
  logic      out_valid;
  logic      out_stall = 1'b0;
  lmwq_rsp_t out_data;
  int        fail_count;
  int        pending;
  int        idle_pct = 0;
  int        stall_pct = 0;
  logic      long_hold_req = 1'b0;
  logic      hold_done = 1'b0;
  int        hold_left = 0;

  always #5 clk = ~clk;

  lock_manager_with_wait_queues dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  lmwq_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (long_hold_req && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= 400;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  function automatic lmwq_req_t mk_req(logic op, logic [7:0] thr, logic [31:0] id);
    lmwq_req_t r;
    r.operation = op;
    r.thread_id = thr;
    r.lock_id   = id;
    return r;
  endfunction

  function automatic lmwq_req_t random_req(int lock_pct);
    lmwq_req_t r;
    int        k;
    r.operation = ($urandom_range(0, 99) < lock_pct) ? OP_LOCK : OP_UNLOCK;
    if ($urandom_range(0, 99) < 80) begin
      k = $urandom_range(0, 2);
      r.thread_id = (k == 2) ? 8'hFF : 8'(k);
    end else begin
      r.thread_id = 8'($urandom);
    end
    if ($urandom_range(0, 99) < 85) begin
      k = $urandom_range(0, 19);
      r.lock_id = (k == 19) ? 32'hFFFF_FFFF : 32'(k);
    end else begin
      r.lock_id = $urandom;
    end
    return r;
  endfunction

  task automatic send_req(lmwq_req_t r);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int idle_tab [8];
    int stall_tab[8];
    int lock_tab [8];
    idle_tab  = '{0, 48, 0, 20, 0, 48, 0, 20};
    stall_tab = '{0, 0, 48, 20, 0, 0, 48, 20};
    lock_tab  = '{70, 40, 70, 30, 60, 65, 35, 50};
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_req(mk_req(OP_LOCK,   8'd0,   32'd0));
    send_req(mk_req(OP_LOCK,   8'd255, 32'hFFFF_FFFF));
    send_req(mk_req(OP_LOCK,   8'd255, 32'd0));
    send_req(mk_req(OP_LOCK,   8'd0,   32'd0));
    send_req(mk_req(OP_UNLOCK, 8'd0,   32'hFFFF_FFFF));
    send_req(mk_req(OP_UNLOCK, 8'd7,   32'h1234_5678));
    send_req(mk_req(OP_UNLOCK, 8'd0,   32'd0));
    send_req(mk_req(OP_UNLOCK, 8'd255, 32'd0));
    send_req(mk_req(OP_UNLOCK, 8'd0,   32'd0));
    for (int i = 1; i <= 15; i++) send_req(mk_req(OP_LOCK, 8'd1, 32'(i)));
    send_req(mk_req(OP_LOCK, 8'd1, 32'd16));
    drain();

    for (int p = 0; p < 8; p++) begin
      idle_pct  = idle_tab[p];
      stall_pct = stall_tab[p];
      if (p == 4) long_hold_req <= 1'b1;
      for (int n = 0; n < 240; n++) send_req(random_req(lock_tab[p]));
      drain();
    end

    repeat (60) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
